// ===== hdl/ece_pkg.sv =====
`timescale 1ns / 1ps

package ece_pkg;

   // width of one adjacency row and of one closure mask
   localparam int ROW_W = 16;
   // bits needed to pick one bit of a row
   localparam int ROW_IDX_W = 4;
   // width of the state count register
   localparam int COUNT_W = 5;

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_PREP,
      ST_CLOSE,
      ST_EMIT
   } state_type;

   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_LOAD,
      CELL_PREP,
      CELL_STEP,
      CELL_SHIFT
   } cell_op_type;

   typedef struct packed {
      cell_op_type          op;
      logic [ROW_W-1:0]     load_data;
      logic [ROW_W-1:0]     live;
      logic [ROW_W-1:0]     pivot_row;
      logic [ROW_IDX_W-1:0] pivot_idx;
   } cell_ctrl_type;

endpackage

// ===== hdl/epsilon_closure_engine_core.sv =====
`timescale 1ns / 1ps

// Epsilon closure engine. Each beat on req_eps_mask (start high while busy is low) loads one
// adjacency row, rows 0 up to n-1 in order, n being the effective state count. The beat
// carrying the last row starts the closure, and busy stays high while it runs. First the
// rows are cleaned, then one pivot per state runs through the ring of row cells (each row
// that holds the pivot state absorbs the pivot row as it moves one cell on), and then the
// finished rows rotate out of the head cell. Results follow in the next cycle from output
// registers, one per cycle, state 0 first, rsp_last on the final one; they are shown for one
// cycle only and must be taken then. csr_wr_data sets state_count (0 reads as 1, values above
// the cell count saturate). Users write it only while the block is idle; nothing enforces it.
module epsilon_closure_engine_core #(
   parameter int MAX_STATES = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [15:0]                       req_eps_mask,
   output logic                              rsp_valid,
   output logic [3:0]                        rsp_state_index,
   output logic [15:0]                       rsp_closure_mask,
   output logic                              rsp_last,
   input  logic                              csr_wr_en,
   input  logic [ece_pkg::COUNT_W-1:0]       csr_wr_data
);

   localparam int NUM_CELLS = (MAX_STATES < ece_pkg::ROW_W) ? MAX_STATES : ece_pkg::ROW_W;
   localparam int IDX_W     = $clog2(NUM_CELLS);
   localparam int CNT_W     = $clog2(NUM_CELLS + 1);

   ece_pkg::state_type state_ff;
   ece_pkg::state_type state_in;

   logic [ece_pkg::COUNT_W-1:0] state_count_ff;
   logic [IDX_W-1:0]            row_cnt_ff;
   logic [IDX_W-1:0]            row_cnt_in;
   logic [IDX_W-1:0]            step_cnt_ff;
   logic [IDX_W-1:0]            step_cnt_in;

   logic                        rsp_valid_ff;
   logic                        rsp_valid_in;
   logic [3:0]                  rsp_state_index_ff;
   logic [3:0]                  rsp_state_index_in;
   logic [ece_pkg::ROW_W-1:0]   rsp_closure_mask_ff;
   logic [ece_pkg::ROW_W-1:0]   rsp_closure_mask_in;
   logic                        rsp_last_ff;
   logic                        rsp_last_in;

   logic [CNT_W-1:0]            n_eff;
   logic [ece_pkg::ROW_W-1:0]   live_mask;
   logic [IDX_W-1:0]            idx_sel;
   logic                        accept;
   logic                        final_row;
   logic                        step_end;

   ece_pkg::cell_ctrl_type      cell_ctrl;
   logic [ece_pkg::ROW_W-1:0]   cell_row  [NUM_CELLS];
   logic [ece_pkg::ROW_W-1:0]   nbr_row   [NUM_CELLS];
   logic [ece_pkg::ROW_W-1:0]   self_bit  [NUM_CELLS];
   logic [NUM_CELLS-1:0]        load_sel;

   // effective count: zero counts as one, large values saturate
   always_comb begin
      if (state_count_ff == '0) begin
         n_eff = CNT_W'(1);
      end else if (state_count_ff > ece_pkg::COUNT_W'(NUM_CELLS)) begin
         n_eff = CNT_W'(NUM_CELLS);
      end else begin
         n_eff = state_count_ff[CNT_W-1:0];
      end
   end

   always_comb begin
      for (int j = 0; j < ece_pkg::ROW_W; j++) begin
         live_mask[j] = (j < int'(n_eff));
      end
   end

   assign busy      = (state_ff != ece_pkg::ST_LOAD);
   assign accept    = start && !busy;
   // a lowered count during a load restarts the pass at row 0
   assign idx_sel   = (CNT_W'(row_cnt_ff) >= n_eff) ? '0 : row_cnt_ff;
   assign final_row = ((CNT_W'(idx_sel) + CNT_W'(1)) >= n_eff);
   assign step_end  = (CNT_W'(step_cnt_ff) == (n_eff - CNT_W'(1)));

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ece_pkg::ST_LOAD: begin
            if (accept && final_row) begin
               state_in = ece_pkg::ST_PREP;
            end
         end
         ece_pkg::ST_PREP: begin
            state_in = ece_pkg::ST_CLOSE;
         end
         ece_pkg::ST_CLOSE: begin
            if (step_end) begin
               state_in = ece_pkg::ST_EMIT;
            end
         end
         ece_pkg::ST_EMIT: begin
            if (step_end) begin
               state_in = ece_pkg::ST_LOAD;
            end
         end
         default: begin
            state_in = ece_pkg::ST_LOAD;
         end
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      cell_ctrl.op        = ece_pkg::CELL_HOLD;
      cell_ctrl.load_data = req_eps_mask;
      cell_ctrl.live      = live_mask;
      cell_ctrl.pivot_row = cell_row[0];
      cell_ctrl.pivot_idx = ece_pkg::ROW_IDX_W'(step_cnt_ff);
      row_cnt_in          = row_cnt_ff;
      step_cnt_in         = step_cnt_ff;
      rsp_valid_in        = 1'b0;
      rsp_state_index_in  = 4'(step_cnt_ff);
      rsp_closure_mask_in = cell_row[0];
      rsp_last_in         = step_end;
      unique case (state_ff)
         ece_pkg::ST_LOAD: begin
            step_cnt_in = '0;
            if (accept) begin
               cell_ctrl.op = ece_pkg::CELL_LOAD;
               row_cnt_in   = final_row ? '0 : (idx_sel + IDX_W'(1));
            end
         end
         ece_pkg::ST_PREP: begin
            cell_ctrl.op = ece_pkg::CELL_PREP;
            step_cnt_in  = '0;
         end
         ece_pkg::ST_CLOSE: begin
            cell_ctrl.op = ece_pkg::CELL_STEP;
            step_cnt_in  = step_end ? '0 : (step_cnt_ff + IDX_W'(1));
         end
         ece_pkg::ST_EMIT: begin
            cell_ctrl.op = ece_pkg::CELL_SHIFT;
            rsp_valid_in = 1'b1;
            step_cnt_in  = step_end ? '0 : (step_cnt_ff + IDX_W'(1));
         end
         default: begin
            cell_ctrl.op = ece_pkg::CELL_HOLD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ece_pkg::ST_LOAD;
         state_count_ff <= ece_pkg::COUNT_W'(16);
         row_cnt_ff     <= '0;
         step_cnt_ff    <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         row_cnt_ff   <= row_cnt_in;
         step_cnt_ff  <= step_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            state_count_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_state_index_ff  <= rsp_state_index_in;
      rsp_closure_mask_ff <= rsp_closure_mask_in;
      rsp_last_ff         <= rsp_last_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_state_index  = rsp_state_index_ff;
   assign rsp_closure_mask = rsp_closure_mask_ff;
   assign rsp_last         = rsp_last_ff;

   // ring of row cells; the last live cell wraps back to the head
   for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
      assign self_bit[i] = ece_pkg::ROW_W'(1) << i;
      assign load_sel[i] = (idx_sel == IDX_W'(i));

      if (i == NUM_CELLS - 1) begin : g_tail
         assign nbr_row[i] = cell_row[0];
      end else begin : g_body
         assign nbr_row[i] = (CNT_W'(i + 1) == n_eff) ? cell_row[0] : cell_row[i+1];
      end

      ece_cell u_cell (
         .clock    (clock),
         .ctrl     (cell_ctrl),
         .load_sel (load_sel[i]),
         .self_bit (self_bit[i]),
         .nbr_row  (nbr_row[i]),
         .row      (cell_row[i])
      );
   end

endmodule

// ===== hdl/ece_cell.sv =====
`timescale 1ns / 1ps

module ece_cell (
   input  logic                          clock,
   input  ece_pkg::cell_ctrl_type        ctrl,
   input  logic                          load_sel,
   input  logic [ece_pkg::ROW_W-1:0]     self_bit,
   input  logic [ece_pkg::ROW_W-1:0]     nbr_row,
   output logic [ece_pkg::ROW_W-1:0]     row
);

   logic [ece_pkg::ROW_W-1:0] row_ff;
   logic [ece_pkg::ROW_W-1:0] row_in;

   always_comb begin
      row_in = row_ff;
      unique case (ctrl.op)
         ece_pkg::CELL_HOLD: begin
            row_in = row_ff;
         end
         ece_pkg::CELL_LOAD: begin
            if (load_sel) begin
               row_in = ctrl.load_data;
            end
         end
         ece_pkg::CELL_PREP: begin
            // drop dead states, every state reaches itself
            row_in = (row_ff & ctrl.live) | self_bit;
         end
         ece_pkg::CELL_STEP: begin
            // row moves one cell toward the head and absorbs the pivot row if it holds the pivot state
            row_in = nbr_row[ctrl.pivot_idx] ? (nbr_row | ctrl.pivot_row) : nbr_row;
         end
         ece_pkg::CELL_SHIFT: begin
            row_in = nbr_row;
         end
         default: begin
            row_in = row_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      row_ff <= row_in;
   end

   assign row = row_ff;

endmodule

// ===== hdl/ece_checker.sv =====
`timescale 1ns / 1ps

module ece_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        rsp_valid,
   input logic [3:0]                  rsp_state_index,
   input logic [15:0]                 rsp_closure_mask,
   input logic                        rsp_last
);

   // results of one closure come as an unbroken burst
   a_burst_continues: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |=> rsp_valid)
      else $error("result burst broken before last beat");

   a_burst_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |=> !rsp_valid)
      else $error("result beat after last beat");

   a_index_steps: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |=> rsp_state_index == $past(rsp_state_index) + 4'd1)
      else $error("state index does not advance by one");

   a_first_index: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> rsp_state_index == 4'd0)
      else $error("burst does not start at state zero");

   a_self_reach: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_closure_mask[rsp_state_index])
      else $error("closure misses its own state");

endmodule

bind epsilon_closure_engine_core ece_checker u_ece_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_state_index  (rsp_state_index),
   .rsp_closure_mask (rsp_closure_mask),
   .rsp_last         (rsp_last)
);
